[src/rbd_pkg.sv]
`default_nettype none

package rbd_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed widths of the request and response fields.
    localparam int OP_W      = 4;
    localparam int IDX_W     = 4;
    localparam int VAL_W     = 32;
    localparam int STAT_W    = 2;
    localparam int CNT_OUT_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 4'd0,
        OP_PUSH_BACK  = 4'd1,
        OP_POP_FRONT  = 4'd2,
        OP_POP_BACK   = 4'd3,
        OP_SET        = 4'd4,
        OP_GET        = 4'd5,
        OP_PEEK_FRONT = 4'd6,
        OP_PEEK_BACK  = 4'd7,
        OP_CLEAR      = 4'd8
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic shr;  // take the left neighbour's element
        logic shl;  // take the right neighbour's element
        logic wr;   // the cell at the write position takes the new value
    } t_cell_ctrl;

endpackage

`default_nettype wire

[src/ring_buffer_deque.sv]
// Channel   Direction  Handshake                  Payload
// request   in         i_in_valid / o_in_ready    i_op, i_index, i_value
// response  out        o_out_valid / i_out_ready  o_data_out, o_status, o_count
//
// Each request's response is registered at the accepting edge and shown from the
// next cycle, and a new request is taken in the same cycle as the previous response
// transfer, so one request per cycle is sustained while responses are taken.
// The elements sit in a chain of cells in logical order; pushes and pops at the
// front move the whole chain by one place in that cycle.
// Reset empties the deque; element contents are not cleared.
// A stalled response holds o_in_ready low until it is taken.
`default_nettype none

module ring_buffer_deque
    import rbd_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [OP_W-1:0]      i_op,
    input  wire logic [IDX_W-1:0]     i_index,
    input  wire logic [VAL_W-1:0]     i_value,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [VAL_W-1:0]          o_data_out,
    output logic [STAT_W-1:0]         o_status,
    output logic [CNT_OUT_W-1:0]      o_count
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_out_valid;
    logic [VAL_W-1:0]      r_data_out;
    t_status               r_status;
    t_status               n_status;
    logic                  n_use_data;

    t_cell_ctrl            w_ctrl;
    t_cell_ctrl            n_ctrl;
    logic [ADDR_W-1:0]     w_wr_pos;
    logic [ADDR_W-1:0]     w_rd_pos;
    logic [DATA_WIDTH-1:0] w_value;
    logic [DATA_WIDTH-1:0] w_data  [DEPTH];
    logic [DATA_WIDTH-1:0] w_rd    [DEPTH];
    logic [DATA_WIDTH-1:0] w_rd_or;

    logic                  w_accept;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_in_range;
    logic [CMP_W-1:0]      w_idx_ext;
    logic [CMP_W-1:0]      w_cnt_ext;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_value    = DATA_WIDTH'(i_value);
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_idx_ext  = CMP_W'(i_index);
    assign w_cnt_ext  = CMP_W'(r_count);
    assign w_in_range = (w_idx_ext < w_cnt_ext);

    always_comb begin
        n_ctrl     = '0;
        n_count    = r_count;
        n_status   = ST_OK;
        n_use_data = 1'b0;
        w_wr_pos   = ADDR_W'(r_count);
        w_rd_pos   = '0;
        case (t_op'(i_op))
            OP_PUSH_FRONT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_ctrl.shr = 1'b1;
                    n_count    = r_count + 1'b1;
                end
            end
            OP_PUSH_BACK: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_ctrl.wr = 1'b1;
                    n_count   = r_count + 1'b1;
                end
            end
            OP_POP_FRONT, OP_PEEK_FRONT: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_use_data = 1'b1;
                    if (t_op'(i_op) == OP_POP_FRONT) begin
                        n_ctrl.shl = 1'b1;
                        n_count    = r_count - 1'b1;
                    end
                end
            end
            OP_POP_BACK, OP_PEEK_BACK: begin
                w_rd_pos = ADDR_W'(r_count - 1'b1);
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_use_data = 1'b1;
                    if (t_op'(i_op) == OP_POP_BACK) begin
                        n_count = r_count - 1'b1;
                    end
                end
            end
            OP_SET, OP_GET: begin
                w_rd_pos = ADDR_W'(w_idx_ext);
                w_wr_pos = ADDR_W'(w_idx_ext);
                if (!w_in_range) begin
                    n_status = ST_RANGE;
                end else begin
                    n_use_data = 1'b1;
                    n_ctrl.wr  = (t_op'(i_op) == OP_SET);
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    // Cells only move when the request is actually transferred.
    assign w_ctrl = w_accept ? n_ctrl : '0;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        rbd_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .ADDR_W     (ADDR_W),
            .POS        (k)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctrl    (w_ctrl),
            .i_wr_pos  (w_wr_pos),
            .i_rd_pos  (w_rd_pos),
            .i_value   (w_value),
            .i_prev    ((k == 0) ? w_value : w_data[(k == 0) ? 0 : k - 1]),
            .i_next    ((k == DEPTH - 1) ? w_data[k] : w_data[(k == DEPTH - 1) ? k : k + 1]),
            .o_data    (w_data[k]),
            .o_rd_data (w_rd[k])
        );
    end

    always_comb begin
        w_rd_or = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_rd_or = w_rd_or | w_rd[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_status    <= ST_OK;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_status    <= n_status;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_data_out <= n_use_data ? VAL_W'(w_rd_or) : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_data_out;
    assign o_status    = r_status;
    assign o_count     = CNT_OUT_W'(r_count);

endmodule

`default_nettype wire

[src/rbd_cell.sv]
`default_nettype none

module rbd_cell
    import rbd_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int ADDR_W     = 4,
    parameter int POS        = 0
) (
    input  wire logic                  i_clk,
    input  wire t_cell_ctrl            i_ctrl,
    input  wire logic [ADDR_W-1:0]     i_wr_pos,
    input  wire logic [ADDR_W-1:0]     i_rd_pos,
    input  wire logic [DATA_WIDTH-1:0] i_value,
    input  wire logic [DATA_WIDTH-1:0] i_prev,
    input  wire logic [DATA_WIDTH-1:0] i_next,
    output logic      [DATA_WIDTH-1:0] o_data,
    output logic      [DATA_WIDTH-1:0] o_rd_data
);

    logic [DATA_WIDTH-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shr) begin
            r_data <= i_prev;
        end else if (i_ctrl.shl) begin
            r_data <= i_next;
        end else if (i_ctrl.wr && (i_wr_pos == ADDR_W'(POS))) begin
            r_data <= i_value;
        end
    end

    assign o_data    = r_data;
    // Only the addressed cell drives its element; the others give zero for the OR.
    assign o_rd_data = (i_rd_pos == ADDR_W'(POS)) ? r_data : '0;

endmodule

`default_nettype wire
